@@ src/mpid_pkg.sv @@
`timescale 1ns / 1ps
package mpid_pkg;

  // Serial unit widths
  localparam int DVD_W  = 48;  // divider dividend and quotient
  localparam int DVS_W  = 32;  // divider divisor
  localparam int GAIN_W = 32;  // Q16.16 gain
  localparam int MX_W   = 33;  // signed multiplier operand
  localparam int CNT_W  = 6;   // serial step counter

  // Frame start byte
  localparam logic [7:0] SYNC_BYTE = 8'hAA;

  // Sensor scaling: y = (raw*2^24 + 10230) / 20460, ie = (raw*25*2^24 + 5626) / 11253
  localparam logic [DVD_W-1:0] POS_RND = 48'd10230;
  localparam logic [DVS_W-1:0] POS_DIV = 32'd20460;
  localparam logic [DVD_W-1:0] CUR_RND = 48'd5626;
  localparam logic [DVS_W-1:0] CUR_DIV = 32'd11253;
  localparam logic [DVS_W-1:0] PCT_DIV = 32'd100;

  // Clamp a wide signed value into the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -36'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ src/mpid_mul.sv @@
`timescale 1ns / 1ps
// Bit-serial gain multiplier: (gain * x) >> 16, floored, saturated to 32 bits.
// One multiplier bit per cycle, then the rounded, saturated result is registered.
module mpid_mul import mpid_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [GAIN_W-1:0]        gain,
  input  logic signed [MX_W-1:0]   x,
  output logic                     done,
  output logic signed [31:0]       result
);

  logic              busy;
  logic              fin;
  logic [CNT_W-1:0]  cnt;
  logic [GAIN_W-1:0] g;
  logic              neg;
  logic [MX_W-1:0]   hi;
  logic [MX_W-1:0]   lo;
  logic [MX_W:0]     step_sum;
  logic [2*MX_W-17:0] q;
  logic [2*MX_W-16:0] qr;
  logic              frac;
  logic signed [31:0] res_c;

  // Add-and-shift step
  assign step_sum = {1'b0, hi} + (lo[0] ? {2'b00, g} : {(MX_W+1){1'b0}});

  // Final scaling, rounding toward minus infinity, saturation
  always_comb begin
    q    = {hi, lo[MX_W-1:16]};
    frac = |lo[15:0];
    qr   = {1'b0, q} + {{(2*MX_W-16){1'b0}}, (neg & frac)};
    if (!neg) begin
      res_c = (q > {{(2*MX_W-48){1'b0}}, 32'h7FFFFFFF}) ? 32'sh7FFFFFFF
                                                         : $signed(q[31:0]);
    end else begin
      res_c = (qr > {{(2*MX_W-48){1'b0}}, 33'h080000000}) ? 32'sh80000000
                                                           : $signed(~qr[31:0] + 32'd1);
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(MX_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      g   <= gain;
      neg <= x[MX_W-1];
      lo  <= x[MX_W-1] ? MX_W'(-x) : MX_W'(x);
      hi  <= '0;
    end else if (busy) begin
      hi <= step_sum[MX_W:1];
      lo <= {step_sum[0], lo[MX_W-1:1]};
    end
    if (fin) begin
      result <= res_c;
    end
  end

endmodule

@@ src/mpid_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module mpid_div import mpid_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] d;
  logic [DVS_W-1:0] rem;
  logic [DVS_W:0]   trial;
  logic             ge;

  assign trial = {rem, quotient[DVD_W-1]};
  assign ge    = trial >= {1'b0, d};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift dividend out, quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      d        <= divisor;
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? DVS_W'(trial - {1'b0, d}) : trial[DVS_W-1:0];
      quotient <= {quotient[DVD_W-2:0], ge};
    end
  end

endmodule

@@ src/maglev_cascaded_pid_controller.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    s_tdata: rx_byte
// m_*       out  m_tvalid/m_tready    m_tdata: pwm_byte
// cfg_*     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Header and data bytes are taken while s_tready is high. The fifth frame byte
// starts the control update: five serial divisions (four with a zero voltage
// limit), five serial multiplications and the DEM, EI and U register steps.
// s_tready is low during the update. Reset is synchronous; the result register
// lets the next frame start while a PWM byte waits on m_tready.
module maglev_cascaded_pid_controller import mpid_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // [7:0] pwm_byte
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [2:0] REG_SETPOINT = 3'd0;
  localparam logic [2:0] REG_POS_KP   = 3'd1;
  localparam logic [2:0] REG_POS_KI   = 3'd2;
  localparam logic [2:0] REG_POS_KD   = 3'd3;
  localparam logic [2:0] REG_CUR_KP   = 3'd4;
  localparam logic [2:0] REG_CUR_KI   = 3'd5;
  localparam logic [2:0] REG_CUR_LIM  = 3'd6;
  localparam logic [2:0] REG_VOLT_LIM = 3'd7;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_Y    = 4'd1;
  localparam logic [3:0] ST_IE   = 4'd2;
  localparam logic [3:0] ST_LOI  = 4'd3;
  localparam logic [3:0] ST_LOV  = 4'd4;
  localparam logic [3:0] ST_P    = 4'd5;
  localparam logic [3:0] ST_D    = 4'd6;
  localparam logic [3:0] ST_I    = 4'd7;
  localparam logic [3:0] ST_DEM  = 4'd8;
  localparam logic [3:0] ST_EI   = 4'd9;
  localparam logic [3:0] ST_PI   = 4'd10;
  localparam logic [3:0] ST_II   = 4'd11;
  localparam logic [3:0] ST_U    = 4'd12;
  localparam logic [3:0] ST_PWM  = 4'd13;
  localparam logic [3:0] ST_OUT  = 4'd14;

  // Configuration registers
  logic [23:0] setpoint;
  logic [31:0] pos_kp, pos_ki, pos_kd, cur_kp, cur_ki;
  logic [30:0] ilim, vlim;

  // Frame and loop state
  logic [3:0]  state;
  logic        launch;
  logic [2:0]  phase;
  logic [15:0] pos_raw;
  logic [7:0]  cur_high;
  logic [15:0] cur_raw;
  logic signed [31:0] y, ie, e, prev_err, p_t, d_t, pos_int, cur_int, dem, pi_t;
  logic signed [32:0] ei;
  logic [30:0] lo_i, lo_v, u;
  logic [7:0]  pwm;

  // Serial units
  logic [DVD_W-1:0]  div_dvd, div_q;
  logic [DVS_W-1:0]  div_dvs;
  logic              div_done;
  logic              div_go, mul_go;
  logic [GAIN_W-1:0] mul_g;
  logic signed [MX_W-1:0] mul_x;
  logic              mul_done;
  logic signed [31:0] mul_res;

  logic [20:0] cur25;
  logic signed [31:0] dem_c, u_sat, pos_int_c, cur_int_c;
  logic [30:0] u_c;
  logic        in_req, out_load;

  function automatic logic signed [31:0] windup(input logic signed [31:0] acc,
                                                input logic signed [31:0] add,
                                                input logic [30:0] lim,
                                                input logic [30:0] lo);
    logic signed [32:0] a, l;
    logic signed [31:0] r;
    a = 33'(acc);
    l = $signed({2'b00, lim});
    if (a < l && a > -l) begin
      r = sat32(36'(acc) + 36'(add));
    end else if (a >= l) begin
      r = $signed({1'b0, lo});
    end else begin
      r = 32'(-$signed({1'b0, lo}));
    end
    return r;
  endfunction

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_req    = s_tvalid & s_tready;
  assign cur25     = 21'(cur_raw) * 21'd25;

  // Start only the unit that the current step uses
  assign div_go = launch & ((state == ST_Y) | (state == ST_IE) | (state == ST_LOI) |
                            (state == ST_LOV) | (state == ST_PWM));
  assign mul_go = launch & ~div_go;

  // Operand select for the serial units
  always_comb begin
    div_dvd = '0;
    div_dvs = PCT_DIV;
    mul_g   = pos_kp;
    mul_x   = 33'(e);
    unique case (state)
      ST_Y:    begin
        div_dvd = {8'd0, pos_raw, 24'd0} + POS_RND;
        div_dvs = POS_DIV;
      end
      ST_IE:   begin
        div_dvd = {3'd0, cur25, 24'd0} + CUR_RND;
        div_dvs = CUR_DIV;
      end
      ST_LOI:  div_dvd = DVD_W'(ilim) * DVD_W'(95);
      ST_LOV:  div_dvd = DVD_W'(vlim) * DVD_W'(95);
      ST_PWM:  begin
        div_dvd = DVD_W'(u) * DVD_W'(254);
        div_dvs = {1'b0, vlim};
      end
      ST_D:    begin
        mul_g = pos_kd;
        mul_x = 33'(e) - 33'(prev_err);
      end
      ST_I:    mul_g = pos_ki;
      ST_PI:   begin
        mul_g = cur_kp;
        mul_x = ei;
      end
      ST_II:   begin
        mul_g = cur_ki;
        mul_x = ei;
      end
      default: ;
    endcase
  end

  // Demand clamp, integrators and drive clamp
  always_comb begin
    pos_int_c = windup(pos_int, mul_res, ilim, lo_i);
    cur_int_c = windup(cur_int, mul_res, vlim, lo_v);
    dem_c = sat32(36'(p_t) + 36'(pos_int) + 36'(d_t));
    if (dem_c > 32'sd0) dem_c = 32'sd0;
    if (33'(dem_c) <= -$signed({2'b00, ilim})) dem_c = 32'(-$signed({2'b00, ilim}));
    u_sat = sat32(36'(pi_t) + 36'(cur_int));
    if (33'(u_sat) > $signed({2'b00, vlim})) u_sat = $signed({1'b0, vlim});
    u_c = (u_sat <= 32'sd0) ? 31'd0 : u_sat[30:0];
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint <= 24'd83886;
      pos_kp   <= 32'd6553600;
      pos_ki   <= 32'd32768;
      pos_kd   <= 32'd9830400;
      cur_kp   <= 32'd786432;
      cur_ki   <= 32'd1966080;
      ilim     <= 31'd13874757;
      vlim     <= 31'd165423349;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SETPOINT: setpoint <= cfg_data[23:0];
        REG_POS_KP:   pos_kp   <= cfg_data;
        REG_POS_KI:   pos_ki   <= cfg_data;
        REG_POS_KD:   pos_kd   <= cfg_data;
        REG_CUR_KP:   cur_kp   <= cfg_data;
        REG_CUR_KI:   cur_ki   <= cfg_data;
        REG_CUR_LIM:  ilim     <= cfg_data[30:0];
        REG_VOLT_LIM: vlim     <= cfg_data[30:0];
      endcase
    end
  end

  // Frame parser and update sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      launch   <= 1'b0;
      phase    <= 3'd0;
      pos_raw  <= '0;
      cur_high <= '0;
      prev_err <= '0;
      pos_int  <= '0;
      cur_int  <= '0;
    end else begin
      launch <= 1'b0;
      unique case (state)
        ST_IDLE: if (in_req) begin
          unique case (phase)
            3'd0: if (s_tdata == SYNC_BYTE) begin
              pos_raw  <= '0;
              cur_high <= '0;
              phase    <= 3'd1;
            end
            3'd1: begin
              pos_raw <= {s_tdata, 8'd0};
              phase   <= 3'd2;
            end
            3'd2: begin
              pos_raw <= pos_raw + {8'd0, s_tdata};
              phase   <= 3'd3;
            end
            3'd3: begin
              cur_high <= s_tdata;
              phase    <= 3'd4;
            end
            default: begin
              cur_raw <= {cur_high, s_tdata};
              phase   <= 3'd0;
              state   <= ST_Y;
              launch  <= 1'b1;
            end
          endcase
        end
        ST_Y: if (div_done) begin
          y      <= $signed(div_q[31:0]);
          state  <= ST_IE;
          launch <= 1'b1;
        end
        ST_IE: if (div_done) begin
          ie     <= (div_q > 48'h00007FFFFFFF) ? 32'sh7FFFFFFF : $signed(div_q[31:0]);
          state  <= ST_LOI;
          launch <= 1'b1;
        end
        ST_LOI: if (div_done) begin
          lo_i   <= div_q[30:0];
          state  <= ST_LOV;
          launch <= 1'b1;
        end
        ST_LOV: if (div_done) begin
          lo_v   <= div_q[30:0];
          e      <= $signed({8'd0, setpoint}) - y;
          state  <= ST_P;
          launch <= 1'b1;
        end
        ST_P: if (mul_done) begin
          p_t    <= mul_res;
          state  <= ST_D;
          launch <= 1'b1;
        end
        ST_D: if (mul_done) begin
          d_t    <= mul_res;
          state  <= ST_I;
          launch <= 1'b1;
        end
        ST_I: if (mul_done) begin
          prev_err <= e;
          pos_int  <= pos_int_c;
          state    <= ST_DEM;
        end
        ST_DEM: begin
          dem   <= dem_c;
          state <= ST_EI;
        end
        ST_EI: begin
          ei     <= -33'(dem) - 33'(ie);
          state  <= ST_PI;
          launch <= 1'b1;
        end
        ST_PI: if (mul_done) begin
          pi_t   <= mul_res;
          state  <= ST_II;
          launch <= 1'b1;
        end
        ST_II: if (mul_done) begin
          cur_int <= cur_int_c;
          state   <= ST_U;
        end
        ST_U: begin
          u <= u_c;
          if (vlim == 31'd0) begin
            pwm   <= 8'd0;
            state <= ST_OUT;
          end else begin
            state  <= ST_PWM;
            launch <= 1'b1;
          end
        end
        ST_PWM: if (div_done) begin
          pwm   <= div_q[7:0];
          state <= ST_OUT;
        end
        ST_OUT: if (out_load) begin
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register
  assign out_load = (state == ST_OUT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= pwm;
    end
  end

  mpid_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  mpid_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_go),
    .gain   (mul_g),
    .x      (mul_x),
    .done   (mul_done),
    .result (mul_res)
  );

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import mpid_pkg::*;

  // Register indexes of the configuration channel
  typedef enum logic [2:0] {
    REG_SETPOINT, REG_POS_KP, REG_POS_KI, REG_POS_KD,
    REG_CUR_KP, REG_CUR_KI, REG_CUR_LIM, REG_VOLT_LIM
  } reg_idx_e;

  localparam int SETTLE_CYCLES = 600;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  maglev_cascaded_pid_controller i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pending serial bytes and expected PWM bytes
  logic [7:0] rx_queue[$];
  logic [7:0] pwm_expect[$];
  int mismatch_count = 0;
  int stall_pct = 0;
  logic hold_go = 1'b0;

  // Controller shadow: registers
  logic [23:0] setpoint;
  logic [31:0] pos_kp, pos_ki, pos_kd, cur_kp, cur_ki;
  logic [30:0] cur_lim, volt_lim;
  // Controller shadow: loop state
  logic [2:0]  frm_phase;
  logic [15:0] pos_raw_q;
  logic [7:0]  cur_hi_q;
  longint      prev_err, pos_integ, cur_integ;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q16.16 gain times Q8.24 value, floor, saturated
  function automatic longint gain_mul(logic [31:0] g, longint x);
    logic neg;
    longint unsigned mag, prod, quo;
    neg = x < 0;
    mag = neg ? longint'(-x) : longint'(x);
    prod = mag * {32'd0, g};
    quo = prod >> 16;
    if (neg) begin
      if (prod[15:0] != 16'd0) quo++;
      return sat32(-longint'(quo));
    end
    return sat32(longint'(quo));
  endfunction

  // Conditional integrator; snaps to 0.95 of the limit when outside it
  function automatic longint integ_step(longint acc, longint add, longint lim);
    longint lo;
    lo = (lim * 95) / 100;
    if (acc < lim && acc > -lim) return sat32(acc + add);
    if (acc >= lim) acc = lo;
    if (acc <= -lim) acc = -lo;
    return acc;
  endfunction

  // Full cascaded update for one completed frame
  task automatic run_control(logic [15:0] cur_raw);
    longint unsigned yu, ieu;
    longint y, ie, ilim, vlim, e, p, d, dem, ei, u;
    yu = ({48'd0, pos_raw_q} * 64'd16777216 + 64'd10230) / 64'd20460;
    ieu = ({48'd0, cur_raw} * 64'd25 * 64'd16777216 + 64'd5626) / 64'd11253;
    y = longint'(yu);
    ie = sat32(longint'(ieu));
    ilim = longint'({33'd0, cur_lim});
    vlim = longint'({33'd0, volt_lim});
    e = longint'({40'd0, setpoint}) - y;
    p = gain_mul(pos_kp, e);
    d = gain_mul(pos_kd, e - prev_err);
    prev_err = e;
    pos_integ = integ_step(pos_integ, gain_mul(pos_ki, e), ilim);
    dem = sat32(p + pos_integ + d);
    if (dem > 0) dem = 0;
    if (dem <= -ilim) dem = -ilim;
    ei = -dem - ie;
    cur_integ = integ_step(cur_integ, gain_mul(cur_ki, ei), vlim);
    u = sat32(gain_mul(cur_kp, ei) + cur_integ);
    if (u > vlim) u = vlim;
    if (u <= 0) u = 0;
    if (vlim == 0) pwm_expect.push_back(8'd0);
    else pwm_expect.push_back(8'(longint'(longint'(u) * 254) / vlim));
  endtask

  // Frame assembler; a result follows only the fifth byte
  task automatic take_byte(logic [7:0] b);
    case (frm_phase)
      3'd0: if (b == SYNC_BYTE) begin
        pos_raw_q = '0;
        cur_hi_q = '0;
        frm_phase = 3'd1;
      end
      3'd1: begin pos_raw_q = {b, 8'd0}; frm_phase = 3'd2; end
      3'd2: begin pos_raw_q = pos_raw_q + {8'd0, b}; frm_phase = 3'd3; end
      3'd3: begin cur_hi_q = b; frm_phase = 3'd4; end
      default: begin frm_phase = 3'd0; run_control({cur_hi_q, b}); end
    endcase
  endtask

  task automatic shadow_reg(logic [2:0] idx, logic [31:0] val);
    case (reg_idx_e'(idx))
      REG_SETPOINT: setpoint = val[23:0];
      REG_POS_KP:   pos_kp = val;
      REG_POS_KI:   pos_ki = val;
      REG_POS_KD:   pos_kd = val;
      REG_CUR_KP:   cur_kp = val;
      REG_CUR_KI:   cur_ki = val;
      REG_CUR_LIM:  cur_lim = val[30:0];
      default:      volt_lim = val[30:0];
    endcase
  endtask

  // Driver: bursts of requests with random gaps, gaps only after an accept
  int burst_left = 1;
  int gap_left = 0;
  always @(posedge clk) begin : drv
    logic nv;
    nv = 1'b0;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        take_byte(s_tdata);
        void'(rx_queue.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end
      if (gap_left > 0) gap_left--;
      else if (rx_queue.size() > 0) nv = 1'b1;
      s_tvalid <= nv;
      if (nv) s_tdata <= rx_queue[0];
    end
  end

  // Receiver: random stall pattern, plus one long hold-off on request
  int hold_left = 0;
  logic hold_done = 1'b0;
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_left = 3000;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Monitor: compare each PWM byte with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pwm_expect.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected pwm_byte %0d", m_tdata);
      end else begin
        if (m_tdata !== pwm_expect[0]) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("pwm_byte mismatch: expected %0d actual %0d", pwm_expect[0], m_tdata);
        end
        void'(pwm_expect.pop_front());
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_reg(idx, val);
  endtask

  task automatic push_frame(logic [15:0] pos, logic [15:0] cur);
    rx_queue.push_back(SYNC_BYTE);
    rx_queue.push_back(pos[15:8]);
    rx_queue.push_back(pos[7:0]);
    rx_queue.push_back(cur[15:8]);
    rx_queue.push_back(cur[7:0]);
  endtask

  task automatic wait_idle();
    while (rx_queue.size() > 0 || pwm_expect.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed frames with random content, some stray bytes
  task automatic random_frames(int n);
    logic [15:0] pos, cur;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) rx_queue.push_back(8'($urandom_range(0, 255)));
      pos = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 400)) : 16'($urandom);
      cur = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 3000)) : 16'($urandom);
      push_frame(pos, cur);
    end
  endtask

  task automatic random_regs();
    for (int r = 0; r < 8; r++) begin
      case ($urandom_range(0, 3))
        0: write_reg(3'(r), $urandom);
        1: write_reg(3'(r), $urandom_range(0, 32'h00FF_FFFF));
        2: write_reg(3'(r), $urandom_range(0, 32'h0100_0000));
        default: write_reg(3'(r), 32'hFFFF_FFFF);
      endcase
    end
  endtask

  initial begin
    setpoint = 24'd83886;
    pos_kp = 32'd6553600;
    pos_ki = 32'd32768;
    pos_kd = 32'd9830400;
    cur_kp = 32'd786432;
    cur_ki = 32'd1966080;
    cur_lim = 31'd13874757;
    volt_lim = 31'd165423349;
    frm_phase = '0;
    pos_raw_q = '0;
    cur_hi_q = '0;
    prev_err = 0;
    pos_integ = 0;
    cur_integ = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: stray bytes, sync inside a frame, field extremes
    rx_queue.push_back(8'h00);
    rx_queue.push_back(8'hFF);
    rx_queue.push_back(8'h55);
    push_frame(16'hAAAA, 16'h00AA);
    push_frame(16'h0000, 16'h0000);
    push_frame(16'hFFFF, 16'hFFFF);
    push_frame(16'h0066, 16'h5555);
    wait_idle();

    // Defaults with the long hold-off
    stall_pct = 30;
    hold_go <= 1'b1;
    random_frames(20);
    wait_idle();

    // All registers at maximum
    stall_pct = 0;
    for (int r = 0; r < 8; r++) write_reg(3'(r), 32'hFFFF_FFFF);
    push_frame(16'h0000, 16'hFFFF);
    random_frames(15);
    wait_idle();

    // Zero gains and zero limits, including the zero voltage limit
    stall_pct = 50;
    for (int r = 0; r < 8; r++) write_reg(3'(r), 32'h0);
    random_frames(10);
    wait_idle();

    // Small limits so the integrators saturate and snap back
    write_reg(REG_SETPOINT, 32'h00FF_FFFF);
    write_reg(REG_POS_KP, 32'h0001_0000);
    write_reg(REG_POS_KI, 32'h0100_0000);
    write_reg(REG_POS_KD, 32'h0);
    write_reg(REG_CUR_KP, 32'h0002_0000);
    write_reg(REG_CUR_KI, 32'h0400_0000);
    write_reg(REG_CUR_LIM, 32'h0000_1000);
    write_reg(REG_VOLT_LIM, 32'd1);
    random_frames(15);
    wait_idle();

    // Random register settings
    for (int ph = 0; ph < 5; ph++) begin
      stall_pct = $urandom_range(0, 70);
      random_regs();
      random_frames(15);
      wait_idle();
    end

    if (mismatch_count == 0 && pwm_expect.size() == 0) begin
      $display("maglev_cascaded_pid_controller regression: pass");
    end else begin
      $display("maglev_cascaded_pid_controller regression: fail");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("maglev_cascaded_pid_controller regression: fail");
    $finish;
  end

endmodule
